/* rtl/sthm_pkg.sv */
`default_nettype none
package sthm_pkg;

  // Linux key codes used by the remapper
  localparam logic [15:0] KC_ESC       = 16'd1;
  localparam logic [15:0] KC_LEFTSHIFT = 16'd42;
  localparam logic [15:0] KC_SPACE     = 16'd57;
  localparam logic [15:0] KC_PAUSE     = 16'd119;
  localparam logic [15:0] KC_LEFTMETA  = 16'd125;

  // Event types
  localparam logic [4:0] EV_SYN = 5'd0;
  localparam logic [4:0] EV_KEY = 5'd1;

  // Key values
  localparam logic [31:0] KV_RELEASE = 32'd0;
  localparam logic [31:0] KV_PRESS   = 32'd1;
  localparam logic [31:0] KV_REPEAT  = 32'd2;

  localparam int COUNT_MAX_DEF   = 31;
  localparam logic [15:0] WINDOW_RST = 16'd200;

  // Longest burst: four events, three SYN reports between them
  localparam int MAX_EV = 4;
  localparam int NUM_W  = $clog2(MAX_EV + 1);
  localparam int POS_W  = $clog2(2 * MAX_EV - 1);

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_HELD = 3'd1,
    MODE_REAL = 3'd3,
    MODE_META = 3'd4
  } mode_e;

  typedef struct packed {
    logic [4:0]  ev_type;
    logic [15:0] code;
    logic [31:0] value;
    logic [31:0] ev_time;
  } evt_t;

  typedef struct packed {
    logic [NUM_W-1:0]    num;
    evt_t [MAX_EV-1:0]   ev;
  } burst_t;

  function automatic evt_t mk_key(logic [15:0] code, logic [31:0] value);
    evt_t e;
    e.ev_type = EV_KEY;
    e.code    = code;
    e.value   = value;
    e.ev_time = 32'd0;
    return e;
  endfunction

endpackage
`default_nettype wire

/* rtl/sthm_core.sv */
`default_nettype none
module sthm_core #(
  parameter int CountMax = sthm_pkg::COUNT_MAX_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             adv_i,
  input  wire sthm_pkg::evt_t   self_i,
  input  wire logic [15:0]      window_i,
  output sthm_pkg::burst_t      burst_o
);

  localparam int CntW = $clog2(CountMax + 1);

  sthm_pkg::mode_e mode_q, mode_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            bufv_q, bufv_d;
  logic            prevf_q, prevf_d;
  logic [15:0]     bufcode_q, bufcode_d;
  logic [31:0]     buftime_q, buftime_d;
  logic [31:0]     prevtime_q, prevtime_d;

  logic            is_key, v_rel, v_prs, v_rep, is_space, recent;
  logic [31:0]     elapsed;
  sthm_pkg::evt_t  buf_ev, syn_ev;

  assign is_key   = (self_i.ev_type == sthm_pkg::EV_KEY);
  assign v_rel    = (self_i.value == sthm_pkg::KV_RELEASE);
  assign v_prs    = (self_i.value == sthm_pkg::KV_PRESS);
  assign v_rep    = (self_i.value == sthm_pkg::KV_REPEAT);
  assign is_space = (self_i.code == sthm_pkg::KC_SPACE);
  assign elapsed  = self_i.ev_time - prevtime_q;
  assign recent   = prevf_q && (elapsed <= {16'd0, window_i});

  always_comb begin
    buf_ev         = sthm_pkg::mk_key(bufcode_q, sthm_pkg::KV_PRESS);
    buf_ev.ev_time = buftime_q;
    syn_ev         = '0;
  end

  always_comb begin
    mode_d     = mode_q;
    cnt_d      = cnt_q;
    bufv_d     = bufv_q;
    prevf_d    = prevf_q;
    bufcode_d  = bufcode_q;
    buftime_d  = buftime_q;
    prevtime_d = prevtime_q;
    burst_o.num = sthm_pkg::NUM_W'(1);
    for (int i = 0; i < sthm_pkg::MAX_EV; i++) burst_o.ev[i] = syn_ev;
    burst_o.ev[0] = self_i;

    if (is_key) begin
      prevf_d    = is_space && v_rel;
      prevtime_d = self_i.ev_time;
      // Track held non-shift keys, saturating at both ends
      if (self_i.code != sthm_pkg::KC_LEFTSHIFT) begin
        if (v_prs && cnt_q < CntW'(CountMax)) cnt_d = cnt_q + CntW'(1);
        else if (v_rel && cnt_q != '0)        cnt_d = cnt_q - CntW'(1);
      end

      priority if (is_space && v_prs) begin
        if (mode_q == sthm_pkg::MODE_IDLE) begin
          if (recent || cnt_d > CntW'(1)) begin
            mode_d = sthm_pkg::MODE_REAL;
          end else begin
            mode_d = sthm_pkg::MODE_HELD;
            burst_o.ev[0] = sthm_pkg::mk_key(sthm_pkg::KC_PAUSE, sthm_pkg::KV_PRESS);
          end
        end
      end else if (is_space && v_rep) begin
        // swallow repeats while the decision is pending
        if (mode_q == sthm_pkg::MODE_HELD) burst_o.num = '0;
      end else if (is_space && v_rel) begin
        mode_d = sthm_pkg::MODE_IDLE;
        if (mode_q == sthm_pkg::MODE_HELD) begin
          bufv_d = 1'b0;
          burst_o.ev[0] = sthm_pkg::mk_key(sthm_pkg::KC_SPACE, sthm_pkg::KV_PRESS);
          burst_o.ev[1] = sthm_pkg::mk_key(sthm_pkg::KC_PAUSE, sthm_pkg::KV_RELEASE);
          burst_o.ev[2] = sthm_pkg::mk_key(sthm_pkg::KC_SPACE, sthm_pkg::KV_RELEASE);
          burst_o.ev[3] = buf_ev;
          burst_o.num   = bufv_q ? sthm_pkg::NUM_W'(4) : sthm_pkg::NUM_W'(3);
        end else if (mode_q == sthm_pkg::MODE_META) begin
          burst_o.ev[0] = sthm_pkg::mk_key(sthm_pkg::KC_LEFTMETA, sthm_pkg::KV_RELEASE);
        end
      end else if (self_i.code == sthm_pkg::KC_ESC && v_prs) begin
        mode_d  = sthm_pkg::MODE_IDLE;
        cnt_d   = '0;
        bufv_d  = 1'b0;
        burst_o.ev[1] = sthm_pkg::mk_key(sthm_pkg::KC_PAUSE, sthm_pkg::KV_RELEASE);
        if (mode_q == sthm_pkg::MODE_HELD) burst_o.num = sthm_pkg::NUM_W'(2);
      end else if (v_rel) begin
        if (mode_q == sthm_pkg::MODE_HELD) begin
          mode_d = sthm_pkg::MODE_META;
          bufv_d = 1'b0;
          burst_o.ev[0] = sthm_pkg::mk_key(sthm_pkg::KC_LEFTMETA, sthm_pkg::KV_PRESS);
          burst_o.ev[1] = sthm_pkg::mk_key(sthm_pkg::KC_PAUSE, sthm_pkg::KV_RELEASE);
          if (bufv_q) begin
            burst_o.ev[2] = buf_ev;
            burst_o.ev[3] = self_i;
            burst_o.num   = sthm_pkg::NUM_W'(4);
          end else begin
            burst_o.ev[2] = self_i;
            burst_o.num   = sthm_pkg::NUM_W'(3);
          end
        end
      end else if (v_prs) begin
        if (mode_q == sthm_pkg::MODE_HELD) begin
          if (bufv_q) begin
            mode_d = sthm_pkg::MODE_META;
            bufv_d = 1'b0;
            burst_o.ev[0] = sthm_pkg::mk_key(sthm_pkg::KC_LEFTMETA, sthm_pkg::KV_PRESS);
            burst_o.ev[1] = buf_ev;
            burst_o.ev[2] = self_i;
            burst_o.num   = sthm_pkg::NUM_W'(3);
          end else begin
            // hold the first press until space resolves
            bufv_d      = 1'b1;
            bufcode_d   = self_i.code;
            buftime_d   = self_i.ev_time;
            burst_o.num = '0;
          end
        end
      end else begin
        burst_o.num = sthm_pkg::NUM_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= sthm_pkg::MODE_IDLE;
      cnt_q   <= '0;
      bufv_q  <= 1'b0;
      prevf_q <= 1'b0;
    end else if (adv_i) begin
      mode_q  <= mode_d;
      cnt_q   <= cnt_d;
      bufv_q  <= bufv_d;
      prevf_q <= prevf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      bufcode_q  <= bufcode_d;
      buftime_q  <= buftime_d;
      prevtime_q <= prevtime_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/sthm_burst.sv */
`default_nettype none
module sthm_burst (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire sthm_pkg::burst_t burst_i,
  output logic                  free_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output sthm_pkg::evt_t        out_ev_o,
  output logic                  last_o
);

  localparam int NumW = sthm_pkg::NUM_W;
  localparam int PosW = sthm_pkg::POS_W;

  sthm_pkg::evt_t [sthm_pkg::MAX_EV-1:0] ev_q;
  logic [NumW-1:0] num_q;
  logic [PosW-1:0] pos_q;
  logic [PosW-1:0] last_pos;
  logic            is_last;

  // Even positions carry events, odd positions the SYN reports between them
  assign last_pos    = PosW'({num_q, 1'b0} - (NumW + 1)'(2));
  assign is_last     = (pos_q == last_pos);
  assign out_valid_o = (num_q != '0);
  assign free_o      = !out_valid_o || (out_ready_i && is_last);
  assign last_o      = is_last;

  always_comb begin
    if (pos_q[0]) out_ev_o = '0;
    else          out_ev_o = ev_q[pos_q[PosW-1:1]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= '0;
      pos_q <= '0;
    end else if (load_i) begin
      num_q <= burst_i.num;
      pos_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      if (is_last) num_q <= '0;
      else         pos_q <= pos_q + PosW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) ev_q <= burst_i.ev;
  end

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o) else $error("burst loaded while busy");

  a_num_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    num_q <= NumW'(sthm_pkg::MAX_EV)) else $error("burst length out of range");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pos_q <= last_pos) else $error("position past end of burst");

  a_syn_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && pos_q[0]) |-> !is_last) else $error("burst ends on a SYN");

endmodule
`default_nettype wire

/* rtl/space_tap_hold_meta_remapper.sv */
// Space tap/hold remapper: tapped space stays space, space held together with
// another key turns into left meta. Non-key events pass through unchanged.
//
// Input channel (in_valid_i / in_ready_o): one input event per request, taken
// into an input register. Output channel (out_valid_o / out_ready_i): one
// emitted event per request; last_o marks the final one caused by an input.
// An input causes zero to seven results: up to four events with SYN reports
// between them, one result per cycle from the burst register while the
// receiver is ready.
// The first result comes from the burst register, which loads from the input register once the burst register is free.
// One input per cycle while each causes at most one result and the receiver
// is ready; an input with several results occupies the burst register until
// its last result is taken, and the input register takes the next request meanwhile.
// Reset clears the mode, held-key count, buffered-press flag and the recent
// space-release flag; the double-tap window returns to 200 ms.
// When the receiver stalls, the current result holds, the input register
// fills and in_ready_o drops until the burst can advance.
// cfg_we_i writes the double-tap window; write only while the block is idle.
`default_nettype none
module space_tap_hold_meta_remapper #(
  parameter int CountMax = sthm_pkg::COUNT_MAX_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [15:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [4:0]         event_type_i,
  input  wire logic [15:0]        event_code_i,
  input  wire logic signed [31:0] event_value_i,
  input  wire logic [31:0]        time_ms_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [4:0]              out_type_o,
  output logic [15:0]             out_code_o,
  output logic signed [31:0]      out_value_o,
  output logic [31:0]             out_time_ms_o,
  output logic                    last_o
);

  logic            iv_q;
  sthm_pkg::evt_t  in_q;
  logic [15:0]     window_q;
  logic            eng_free, xfer, in_acc;
  sthm_pkg::burst_t burst;
  sthm_pkg::evt_t  out_ev;

  // Advance the held request into the decoder when the burst register frees up
  assign xfer       = iv_q && eng_free;
  assign in_ready_o = !iv_q || xfer;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q     <= 1'b0;
      window_q <= sthm_pkg::WINDOW_RST;
    end else begin
      if (in_acc)    iv_q <= 1'b1;
      else if (xfer) iv_q <= 1'b0;
      if (cfg_we_i) window_q <= cfg_wdata_i;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q.ev_type <= event_type_i;
      in_q.code    <= event_code_i;
      in_q.value   <= event_value_i;
      in_q.ev_time <= time_ms_i;
    end
  end

  sthm_core #(
    .CountMax (CountMax)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (xfer),
    .self_i   (in_q),
    .window_i (window_q),
    .burst_o  (burst)
  );

  // A request with no results just updates state and never loads the burst
  sthm_burst u_burst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (xfer && (burst.num != '0)),
    .burst_i     (burst),
    .free_o      (eng_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_ev_o    (out_ev),
    .last_o      (last_o)
  );

  assign out_type_o    = out_ev.ev_type;
  assign out_code_o    = out_ev.code;
  assign out_value_o   = out_ev.value;
  assign out_time_ms_o = out_ev.ev_time;

endmodule
`default_nettype wire
